// ----- rtl/core/copying_heap_collector_defines.svh -----
// ----------------------------------------------------------------------------
// copying_heap_collector_defines
// assertion macros for the collector rtl
// ----------------------------------------------------------------------------
`ifndef COPYING_HEAP_COLLECTOR_DEFINES_SVH
`define COPYING_HEAP_COLLECTOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define CHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("copying_heap_collector assertion failed");
`define CHC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("copying_heap_collector assertion failed");
`else
`define CHC_ASSERT_IMP(lbl, ante, cons)
`define CHC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/chc_pkg.sv -----
// ----------------------------------------------------------------------------
// chc_pkg
// types, codes and defaults shared by the copying heap collector
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int HEAP_CELLS_DEF = 1024;
  localparam int ROOT_DEPTH_DEF = 64;
  localparam int HASH_SLOTS_DEF = 16;
  localparam int SIZE_W         = 11;
  localparam int PAIR_SPAN      = 2;
  localparam int PROC_SPAN      = 3;

  localparam logic [2:0] ACT_ALLOC      = 3'd0;
  localparam logic [2:0] ACT_WRITE_CELL = 3'd1;
  localparam logic [2:0] ACT_READ_CELL  = 3'd2;
  localparam logic [2:0] ACT_PUSH_ROOT  = 3'd3;
  localparam logic [2:0] ACT_POP_ROOT   = 3'd4;
  localparam logic [2:0] ACT_READ_ROOT  = 3'd5;
  localparam logic [2:0] ACT_WRITE_ROOT = 3'd6;
  localparam logic [2:0] ACT_COLLECT    = 3'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OOM       = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd4;

  localparam logic [3:0] TAG_NIL       = 4'd6;
  localparam logic [3:0] TAG_FIRST_REF = 4'd10;
  localparam logic [3:0] TAG_HASH      = 4'd11;
  localparam logic [3:0] TAG_PROC      = 4'd12;
  localparam logic [3:0] TAG_MACRO     = 4'd13;
  localparam logic [3:0] TAG_VECTOR    = 4'd15;

  typedef logic [5:0] cmd_t;

  localparam cmd_t CMD_NONE       = 6'd0;
  localparam cmd_t CMD_LOAD       = 6'd1;
  localparam cmd_t CMD_COL_INIT   = 6'd2;
  localparam cmd_t CMD_ROOT_RDI   = 6'd3;
  localparam cmd_t CMD_LOAD_ROOT  = 6'd4;
  localparam cmd_t CMD_SCAN_RD    = 6'd5;
  localparam cmd_t CMD_LOAD_SCAN  = 6'd6;
  localparam cmd_t CMD_EV_IMM     = 6'd7;
  localparam cmd_t CMD_EV_LOOK    = 6'd8;
  localparam cmd_t CMD_EV_FWD     = 6'd9;
  localparam cmd_t CMD_EV_ZERO    = 6'd10;
  localparam cmd_t CMD_EV_PLAN    = 6'd11;
  localparam cmd_t CMD_EV_RD      = 6'd12;
  localparam cmd_t CMD_EV_WR      = 6'd13;
  localparam cmd_t CMD_EV_MARK    = 6'd14;
  localparam cmd_t CMD_RET_ROOT   = 6'd15;
  localparam cmd_t CMD_RET_SCAN   = 6'd16;
  localparam cmd_t CMD_BACK_INIT  = 6'd17;
  localparam cmd_t CMD_BACK_RD    = 6'd18;
  localparam cmd_t CMD_BACK_WR    = 6'd19;
  localparam cmd_t CMD_COL_END    = 6'd20;
  localparam cmd_t CMD_ALLOC_INIT = 6'd21;
  localparam cmd_t CMD_ALLOC_CLR  = 6'd22;
  localparam cmd_t CMD_ALLOC_END  = 6'd23;
  localparam cmd_t CMD_OOM        = 6'd24;
  localparam cmd_t CMD_CELL_WR    = 6'd25;
  localparam cmd_t CMD_CELL_RD    = 6'd26;
  localparam cmd_t CMD_CELL_RES   = 6'd27;
  localparam cmd_t CMD_BAD        = 6'd28;
  localparam cmd_t CMD_PUSH       = 6'd29;
  localparam cmd_t CMD_OVF        = 6'd30;
  localparam cmd_t CMD_POP        = 6'd31;
  localparam cmd_t CMD_UNF        = 6'd32;
  localparam cmd_t CMD_ROOT_RD    = 6'd33;
  localparam cmd_t CMD_ROOT_RES   = 6'd34;
  localparam cmd_t CMD_ROOT_WR    = 6'd35;
  localparam cmd_t CMD_OUT_LOAD   = 6'd36;

  typedef struct packed {
    logic [3:0]  tag;
    logic [31:0] payload;
    logic [10:0] length;
  } val_t;

  typedef struct packed {
    logic [2:0] act;
    logic       fits;
    logic       cell_ok;
    logic       root_full;
    logic       root_empty;
    logic       root_ok;
    logic       root_more;
    logic       scan_more;
    logic       ev_imm;
    logic       ev_moved;
    logic       ev_zero;
    logic       ev_nz;
    logic       cnt_last;
    logic       back_last;
    logic       clr_done;
  } dp_status_t;

endpackage

// ----- rtl/core/chc_in_if.sv -----
// ----------------------------------------------------------------------------
// chc_in_if
// request channel of the copying heap collector
// ----------------------------------------------------------------------------
interface chc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [10:0] alloc_size;
  logic [9:0]  address;
  logic [3:0]  value_tag;
  logic [31:0] value_payload;
  logic [10:0] value_length;

  modport source (
    output valid, action, alloc_size, address, value_tag, value_payload, value_length,
    input  ready
  );
  modport sink (
    input  valid, action, alloc_size, address, value_tag, value_payload, value_length,
    output ready
  );
endinterface

// ----- rtl/core/chc_out_if.sv -----
// ----------------------------------------------------------------------------
// chc_out_if
// response channel of the copying heap collector
// ----------------------------------------------------------------------------
interface chc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  alloc_start;
  logic [3:0]  read_tag;
  logic [31:0] read_payload;
  logic [10:0] read_length;
  logic        collected;

  modport source (
    output valid, status, alloc_start, read_tag, read_payload, read_length, collected,
    input  ready
  );
  modport sink (
    input  valid, status, alloc_start, read_tag, read_payload, read_length, collected,
    output ready
  );
endinterface

// ----- rtl/core/chc_ctrl.sv -----
// ----------------------------------------------------------------------------
// chc_ctrl
// sequencer for allocation, cell and root access and copying collection
// ----------------------------------------------------------------------------
module chc_ctrl import chc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_status_t st,
  output cmd_t       cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DEC      = 5'd1;
  localparam logic [4:0] S_A_CHK    = 5'd2;
  localparam logic [4:0] S_A_CLR    = 5'd3;
  localparam logic [4:0] S_CELL_RES = 5'd4;
  localparam logic [4:0] S_ROOT_RES = 5'd5;
  localparam logic [4:0] S_C_INIT   = 5'd6;
  localparam logic [4:0] S_R_CHK    = 5'd7;
  localparam logic [4:0] S_R_LOAD   = 5'd8;
  localparam logic [4:0] S_S_CHK    = 5'd9;
  localparam logic [4:0] S_S_LOAD   = 5'd10;
  localparam logic [4:0] S_EV_TEST  = 5'd11;
  localparam logic [4:0] S_EV_MOVED = 5'd12;
  localparam logic [4:0] S_EV_RD    = 5'd13;
  localparam logic [4:0] S_EV_WR    = 5'd14;
  localparam logic [4:0] S_EV_MARK  = 5'd15;
  localparam logic [4:0] S_EV_RET   = 5'd16;
  localparam logic [4:0] S_B_RD     = 5'd17;
  localparam logic [4:0] S_B_WR     = 5'd18;
  localparam logic [4:0] S_C_END    = 5'd19;
  localparam logic [4:0] S_OUT      = 5'd20;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       in_scan;
  logic       after_col;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_OUT;
        unique case (st.act)
          ACT_ALLOC: state_next = S_A_CHK;
          ACT_WRITE_CELL: cmd = st.cell_ok ? CMD_CELL_WR : CMD_BAD;
          ACT_READ_CELL: begin
            cmd = st.cell_ok ? CMD_CELL_RD : CMD_BAD;
            if (st.cell_ok) state_next = S_CELL_RES;
          end
          ACT_PUSH_ROOT: cmd = st.root_full ? CMD_OVF : CMD_PUSH;
          ACT_POP_ROOT: cmd = st.root_empty ? CMD_UNF : CMD_POP;
          ACT_READ_ROOT: begin
            cmd = st.root_ok ? CMD_ROOT_RD : CMD_BAD;
            if (st.root_ok) state_next = S_ROOT_RES;
          end
          ACT_WRITE_ROOT: cmd = st.root_ok ? CMD_ROOT_WR : CMD_BAD;
          default: state_next = S_C_INIT;
        endcase
      end
      S_A_CHK: begin
        if (st.fits) begin
          cmd        = CMD_ALLOC_INIT;
          state_next = S_A_CLR;
        end else if (after_col) begin
          cmd        = CMD_OOM;
          state_next = S_OUT;
        end else begin
          state_next = S_C_INIT;
        end
      end
      S_A_CLR: begin
        if (st.clr_done) begin
          cmd        = CMD_ALLOC_END;
          state_next = S_OUT;
        end else begin
          cmd = CMD_ALLOC_CLR;
        end
      end
      S_CELL_RES: begin
        cmd        = CMD_CELL_RES;
        state_next = S_OUT;
      end
      S_ROOT_RES: begin
        cmd        = CMD_ROOT_RES;
        state_next = S_OUT;
      end
      S_C_INIT: begin
        cmd        = CMD_COL_INIT;
        state_next = S_R_CHK;
      end
      S_R_CHK: begin
        if (st.root_more) begin
          cmd        = CMD_ROOT_RDI;
          state_next = S_R_LOAD;
        end else begin
          state_next = S_S_CHK;
        end
      end
      S_R_LOAD: begin
        cmd        = CMD_LOAD_ROOT;
        state_next = S_EV_TEST;
      end
      S_S_CHK: begin
        if (st.scan_more) begin
          cmd        = CMD_SCAN_RD;
          state_next = S_S_LOAD;
        end else begin
          cmd        = CMD_BACK_INIT;
          state_next = S_B_RD;
        end
      end
      S_S_LOAD: begin
        cmd        = CMD_LOAD_SCAN;
        state_next = S_EV_TEST;
      end
      S_EV_TEST: begin
        if (st.ev_imm) begin
          cmd        = CMD_EV_IMM;
          state_next = S_EV_RET;
        end else begin
          cmd        = CMD_EV_LOOK;
          state_next = S_EV_MOVED;
        end
      end
      S_EV_MOVED: begin
        if (st.ev_moved) begin
          cmd        = CMD_EV_FWD;
          state_next = S_EV_RET;
        end else if (st.ev_zero) begin
          cmd        = CMD_EV_ZERO;
          state_next = S_EV_RET;
        end else begin
          cmd        = CMD_EV_PLAN;
          state_next = st.ev_nz ? S_EV_RD : S_EV_MARK;
        end
      end
      S_EV_RD: begin
        cmd        = CMD_EV_RD;
        state_next = S_EV_WR;
      end
      S_EV_WR: begin
        cmd        = CMD_EV_WR;
        state_next = st.cnt_last ? S_EV_MARK : S_EV_RD;
      end
      S_EV_MARK: begin
        cmd        = CMD_EV_MARK;
        state_next = S_EV_RET;
      end
      S_EV_RET: begin
        cmd        = in_scan ? CMD_RET_SCAN : CMD_RET_ROOT;
        state_next = in_scan ? S_S_CHK : S_R_CHK;
      end
      S_B_RD: begin
        cmd        = CMD_BACK_RD;
        state_next = S_B_WR;
      end
      S_B_WR: begin
        cmd        = CMD_BACK_WR;
        state_next = st.back_last ? S_C_END : S_B_RD;
      end
      S_C_END: begin
        cmd        = CMD_COL_END;
        state_next = (st.act == ACT_ALLOC) ? S_A_CHK : S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd        = CMD_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_scan   <= 1'b0;
      after_col <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_R_LOAD) in_scan <= 1'b0;
      if (state == S_S_LOAD) in_scan <= 1'b1;
      if (state == S_IDLE) after_col <= 1'b0;
      if (state == S_C_END) after_col <= 1'b1;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/chc_dpath.sv -----
// ----------------------------------------------------------------------------
// chc_dpath
// heap, root stack, pointers and result registers of the collector
// ----------------------------------------------------------------------------
module chc_dpath import chc_pkg::*; #(
  parameter int HEAP_CELLS = HEAP_CELLS_DEF,
  parameter int ROOT_DEPTH = ROOT_DEPTH_DEF,
  parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [2:0]  action,
  input  logic [10:0] alloc_size,
  input  logic [9:0]  address,
  input  logic [3:0]  value_tag,
  input  logic [31:0] value_payload,
  input  logic [10:0] value_length,
  output dp_status_t  st,
  output logic [2:0]  status,
  output logic [9:0]  alloc_start,
  output logic [3:0]  read_tag,
  output logic [31:0] read_payload,
  output logic [10:0] read_length,
  output logic        collected
);

  localparam int AW  = $clog2(HEAP_CELLS);
  localparam int CAW = $clog2(2 * HEAP_CELLS);
  localparam int CW  = $clog2(HEAP_CELLS + 1);
  localparam int RIW = $clog2(ROOT_DEPTH);
  localparam int RW  = $clog2(ROOT_DEPTH + 1);
  localparam int HW  = $clog2(HASH_SLOTS + 1);
  localparam int M1  = (CW > RW) ? CW : RW;
  localparam int M2  = (M1 > SIZE_W) ? M1 : SIZE_W;
  localparam int IW  = (M2 > HW) ? M2 : HW;
  localparam int XW  = IW + 1;

  val_t cell_mem [2*HEAP_CELLS];
  logic moved_mem [HEAP_CELLS];
  logic [CW-1:0] fwd_mem [HEAP_CELLS];
  val_t root_mem [ROOT_DEPTH];

  val_t          cell_rd;
  logic          moved_rd;
  logic [CW-1:0] fwd_rd;
  val_t          root_rd;

  logic [2:0]     act;
  logic [10:0]    size;
  logic [9:0]     addr;
  val_t           item;
  logic [CW-1:0]  bump;
  logic [RW-1:0]  rc;
  logic [CW-1:0]  fill;
  logic [CW-1:0]  scan;
  logic [IW-1:0]  idx;
  val_t           ev;
  logic [31:0]    ev_res;
  logic [CW-1:0]  ev_n;
  logic [CW-1:0]  ev_cnt;
  logic [CAW-1:0] ev_src;
  logic [CAW-1:0] ev_dst;
  logic [2:0]     r_status;
  logic [9:0]     r_start;
  val_t           r_val;
  logic           r_coll;

  logic [XW-1:0] span;
  logic [XW-1:0] lim_src;
  logic [XW-1:0] lim_dst;
  logic [XW-1:0] n_a;
  logic [XW-1:0] n_plan;
  logic [XW-1:0] clr_sum;
  val_t          ret_val;

  logic           cell_we;
  logic [CAW-1:0] cell_wa;
  val_t           cell_wd;
  logic [CAW-1:0] cell_ra;
  logic           moved_we;
  logic [AW-1:0]  moved_wa;
  logic           moved_wd;
  logic           fwd_we;
  logic [AW-1:0]  look_a;
  logic           root_we;
  logic [RIW-1:0] root_wa;
  val_t           root_wd;
  logic [RIW-1:0] root_ra;

  always_comb begin
    case (ev.tag) inside
      TAG_HASH:             span = XW'(HASH_SLOTS);
      TAG_PROC, TAG_MACRO:  span = XW'(PROC_SPAN);
      TAG_VECTOR:           span = XW'(ev.length);
      default:              span = XW'(PAIR_SPAN);
    endcase
  end

  assign lim_src = XW'(HEAP_CELLS) - XW'(ev.payload[CW-1:0]);
  assign lim_dst = XW'(HEAP_CELLS) - XW'(fill);
  assign n_a     = (span < lim_src) ? span : lim_src;
  assign n_plan  = (n_a < lim_dst) ? n_a : lim_dst;
  assign clr_sum = XW'(bump) + XW'(idx);
  assign ret_val = '{tag: ev.tag, payload: ev_res, length: ev.length};
  assign look_a  = ev.payload[AW-1:0];

  always_comb begin
    st.act        = act;
    st.fits       = (XW'(bump) + XW'(size)) < XW'(HEAP_CELLS);
    st.cell_ok    = XW'(addr) < XW'(bump);
    st.root_full  = XW'(rc) >= XW'(ROOT_DEPTH);
    st.root_empty = (rc == '0);
    st.root_ok    = XW'(addr) < XW'(rc);
    st.root_more  = XW'(idx) < XW'(rc);
    st.scan_more  = scan < fill;
    st.ev_imm     = (ev.tag < TAG_FIRST_REF) || (ev.payload >= 32'(HEAP_CELLS));
    st.ev_moved   = moved_rd;
    st.ev_zero    = (span == '0);
    st.ev_nz      = (n_plan != '0);
    st.cnt_last   = (ev_cnt == CW'(1));
    st.back_last  = (idx == IW'(HEAP_CELLS - 1));
    st.clr_done   = (XW'(idx) == XW'(size));
  end

  always_comb begin
    cell_we  = 1'b0;
    cell_wa  = CAW'(addr);
    cell_wd  = item;
    cell_ra  = CAW'(addr);
    moved_we = 1'b0;
    moved_wa = look_a;
    moved_wd = 1'b0;
    fwd_we   = 1'b0;
    root_we  = 1'b0;
    root_wa  = RIW'(addr);
    root_wd  = item;
    root_ra  = RIW'(addr);
    unique case (cmd)
      CMD_CELL_WR: cell_we = 1'b1;
      CMD_SCAN_RD: cell_ra = CAW'(HEAP_CELLS) + CAW'(scan);
      CMD_EV_RD:   cell_ra = ev_src;
      CMD_EV_WR: begin
        cell_we = 1'b1;
        cell_wa = ev_dst;
        cell_wd = cell_rd;
      end
      CMD_RET_SCAN: begin
        cell_we = 1'b1;
        cell_wa = CAW'(HEAP_CELLS) + CAW'(scan);
        cell_wd = ret_val;
      end
      CMD_BACK_RD: cell_ra = CAW'(HEAP_CELLS) + CAW'(idx);
      CMD_BACK_WR: begin
        cell_we  = XW'(idx) < XW'(fill);
        cell_wa  = CAW'(idx);
        cell_wd  = cell_rd;
        moved_we = 1'b1;
        moved_wa = AW'(idx);
      end
      CMD_ALLOC_CLR: begin
        cell_we  = 1'b1;
        cell_wa  = CAW'(clr_sum);
        cell_wd  = '{tag: TAG_NIL, payload: 32'd0, length: 11'd0};
        moved_we = 1'b1;
        moved_wa = AW'(clr_sum);
      end
      CMD_EV_MARK: begin
        moved_we = 1'b1;
        moved_wd = 1'b1;
        fwd_we   = 1'b1;
      end
      CMD_ROOT_RDI: root_ra = RIW'(idx);
      CMD_PUSH: begin
        root_we = 1'b1;
        root_wa = RIW'(rc);
      end
      CMD_ROOT_WR: root_we = 1'b1;
      CMD_RET_ROOT: begin
        root_we = 1'b1;
        root_wa = RIW'(idx);
        root_wd = ret_val;
      end
      default: cell_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_rd <= cell_mem[cell_ra];
    if (moved_we) moved_mem[moved_wa] <= moved_wd;
    if (fwd_we) fwd_mem[look_a] <= fill;
    moved_rd <= moved_mem[look_a];
    fwd_rd   <= fwd_mem[look_a];
    if (root_we) root_mem[root_wa] <= root_wd;
    root_rd <= root_mem[root_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump <= '0;
      rc   <= '0;
      fill <= '0;
      scan <= '0;
      act  <= ACT_ALLOC;
    end else begin
      unique case (cmd)
        CMD_LOAD: begin
          act      <= action;
          size     <= alloc_size;
          addr     <= address;
          item     <= '{tag: value_tag, payload: value_payload, length: value_length};
          r_status <= ST_OK;
          r_start  <= '0;
          r_val    <= '0;
          r_coll   <= 1'b0;
        end
        CMD_COL_INIT: begin
          fill <= '0;
          scan <= '0;
          idx  <= '0;
        end
        CMD_LOAD_ROOT: ev <= root_rd;
        CMD_LOAD_SCAN: ev <= cell_rd;
        CMD_EV_IMM:    ev_res <= ev.payload;
        CMD_EV_FWD:    ev_res <= 32'(fwd_rd);
        CMD_EV_ZERO:   ev_res <= 32'(fill);
        CMD_EV_PLAN: begin
          ev_res <= 32'(fill);
          ev_n   <= CW'(n_plan);
          ev_cnt <= CW'(n_plan);
          ev_src <= CAW'(ev.payload[CW-1:0]);
          ev_dst <= CAW'(HEAP_CELLS) + CAW'(fill);
        end
        CMD_EV_RD:  ev_src <= ev_src + CAW'(1);
        CMD_EV_WR: begin
          ev_dst <= ev_dst + CAW'(1);
          ev_cnt <= ev_cnt - CW'(1);
        end
        CMD_EV_MARK:   fill <= fill + ev_n;
        CMD_RET_ROOT:  idx <= idx + IW'(1);
        CMD_RET_SCAN:  scan <= scan + CW'(1);
        CMD_BACK_INIT: idx <= '0;
        CMD_BACK_WR:   idx <= idx + IW'(1);
        CMD_COL_END: begin
          bump   <= fill;
          r_coll <= 1'b1;
        end
        CMD_ALLOC_INIT: begin
          r_start <= 10'(bump);
          idx     <= '0;
        end
        CMD_ALLOC_CLR: idx <= idx + IW'(1);
        CMD_ALLOC_END: bump <= CW'(XW'(bump) + XW'(size));
        CMD_OOM:       r_status <= ST_OOM;
        CMD_CELL_RES:  r_val <= cell_rd;
        CMD_BAD:       r_status <= ST_BAD_ADDR;
        CMD_PUSH:      rc <= rc + RW'(1);
        CMD_OVF:       r_status <= ST_OVERFLOW;
        CMD_POP:       rc <= rc - RW'(1);
        CMD_UNF:       r_status <= ST_UNDERFLOW;
        CMD_ROOT_RES:  r_val <= root_rd;
        CMD_OUT_LOAD: begin
          status       <= r_status;
          alloc_start  <= r_start;
          read_tag     <= r_val.tag;
          read_payload <= r_val.payload;
          read_length  <= r_val.length;
          collected    <= r_coll;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/copying_heap_collector.sv -----
// ----------------------------------------------------------------------------
// copying_heap_collector
// tagged-cell heap with bump allocation and a semispace copying collector
// ----------------------------------------------------------------------------
// in_ch carries one request per transaction; out_ch returns exactly one
// response per request, in order. one request is worked at a time.
// an allocation sets its fresh cells to nil one per cycle through the single
// heap write port. a collection evacuates each root and each scanned cell,
// copying each object cell by cell, and ends with a copy-back pass over the
// whole heap that moves to-space down to address 0 and clears the moved flags.
// the response sits in an output register: a new request is taken while it
// waits, and work stops only when the next response finds the register full.
// reset empties the heap and the root stack; there is no clearing pass, and
// cells never written read back as undefined.
// ----------------------------------------------------------------------------
`include "copying_heap_collector_defines.svh"

module copying_heap_collector import chc_pkg::*; #(
  parameter int HEAP_CELLS = HEAP_CELLS_DEF,
  parameter int ROOT_DEPTH = ROOT_DEPTH_DEF,
  parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  chc_in_if.sink    in_ch,
  chc_out_if.source out_ch
);

  cmd_t       cmd;
  dp_status_t st;

  chc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .st        (st),
    .cmd       (cmd)
  );

  chc_dpath #(
    .HEAP_CELLS (HEAP_CELLS),
    .ROOT_DEPTH (ROOT_DEPTH),
    .HASH_SLOTS (HASH_SLOTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (in_ch.action),
    .alloc_size    (in_ch.alloc_size),
    .address       (in_ch.address),
    .value_tag     (in_ch.value_tag),
    .value_payload (in_ch.value_payload),
    .value_length  (in_ch.value_length),
    .st            (st),
    .status        (out_ch.status),
    .alloc_start   (out_ch.alloc_start),
    .read_tag      (out_ch.read_tag),
    .read_payload  (out_ch.read_payload),
    .read_length   (out_ch.read_length),
    .collected     (out_ch.collected)
  );

  `CHC_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `CHC_ASSERT_IMP(a_oom_collected, out_ch.valid && out_ch.status == ST_OOM, out_ch.collected)
  `CHC_ASSERT_IMP(a_fail_no_data, out_ch.valid && out_ch.status != ST_OK, out_ch.read_tag == 4'd0 && out_ch.alloc_start == 10'd0)

endmodule

// ----- test/copying_heap_collector_test.sv -----
// ----------------------------------------------------------------------------
// copying_heap_collector_test
// self-checking bench for the copying heap collector: every request is run
// through a behavioural heap model as it is sent, and each response is
// compared field by field, in order, with the predicted one. directed cases
// cover the bounds and error codes, random traffic with gaps and stalls on
// both channels covers allocation, cell and root access and collection.
// ----------------------------------------------------------------------------
module copying_heap_collector_test import chc_pkg::*;;

  localparam int NCELLS = HEAP_CELLS_DEF;
  localparam int NROOTS = ROOT_DEPTH_DEF;

  typedef struct {
    logic [2:0]  action;
    logic [10:0] size;
    logic [9:0]  addr;
    logic [3:0]  tag;
    logic [31:0] payload;
    logic [10:0] len;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  start;
    logic [3:0]  rtag;
    logic [31:0] rpay;
    logic [10:0] rlen;
    logic        coll;
  } response_t;

  logic clk = 0;
  logic rst = 1;

  chc_in_if  in_ch();
  chc_out_if out_ch();

  copying_heap_collector dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // heap image: from-space then to-space
  logic [3:0]  cell_tag_m [2*NCELLS];
  logic [31:0] cell_pay_m [2*NCELLS];
  logic [10:0] cell_len_m [2*NCELLS];
  bit          cell_moved_m [2*NCELLS];
  int unsigned cell_fwd_m [2*NCELLS];
  logic [3:0]  root_tag_m [NROOTS];
  logic [31:0] root_pay_m [NROOTS];
  logic [10:0] root_len_m [NROOTS];
  int unsigned bump, to_fill, root_count;
  int unsigned written_top;

  response_t pending_q[$];
  int errors, sent, checked, n_collect, n_oom, n_bad, n_ovf, n_unf;
  int hold_cycles;
  bit steady_ready, no_gaps;

  function automatic int unsigned object_span(logic [3:0] t, logic [10:0] l);
    if (t == TAG_HASH) return HASH_SLOTS_DEF;
    if (t == TAG_PROC || t == TAG_MACRO) return PROC_SPAN;
    if (t == TAG_VECTOR) return l;
    return PAIR_SPAN;
  endfunction

  function automatic logic [31:0] evacuate_value(logic [3:0] t, logic [31:0] p,
                                                 logic [10:0] l);
    int unsigned sz, n, d;
    logic [31:0] r;
    if (t < TAG_FIRST_REF) return p;
    if (p >= NCELLS) return p;
    if (cell_moved_m[p]) return cell_fwd_m[p];
    sz = object_span(t, l);
    if (sz == 0) return to_fill;
    n = sz;
    if (n > NCELLS - p) n = NCELLS - p;
    if (n > NCELLS - to_fill) n = NCELLS - to_fill;
    for (int i = 0; i < n; i++) begin
      d = NCELLS + to_fill + i;
      cell_tag_m[d] = cell_tag_m[p + i];
      cell_pay_m[d] = cell_pay_m[p + i];
      cell_len_m[d] = cell_len_m[p + i];
      cell_moved_m[d] = 0;
    end
    cell_moved_m[p] = 1;
    cell_fwd_m[p] = to_fill;
    r = to_fill;
    to_fill += n;
    return r;
  endfunction

  function automatic void collect_heap();
    int unsigned scan, c;
    to_fill = 0;
    scan = 0;
    for (int i = 0; i < root_count; i++)
      root_pay_m[i] = evacuate_value(root_tag_m[i], root_pay_m[i], root_len_m[i]);
    while (scan < to_fill) begin
      c = NCELLS + scan;
      cell_pay_m[c] = evacuate_value(cell_tag_m[c], cell_pay_m[c], cell_len_m[c]);
      scan++;
    end
    for (int i = 0; i < NCELLS; i++) begin
      if (i < to_fill) begin
        cell_tag_m[i] = cell_tag_m[NCELLS + i];
        cell_pay_m[i] = cell_pay_m[NCELLS + i];
        cell_len_m[i] = cell_len_m[NCELLS + i];
      end
      cell_moved_m[i] = 0;
    end
    bump = to_fill;
    if (to_fill > written_top) written_top = to_fill;
    n_collect++;
  endfunction

  function automatic response_t heap_step(request_t r);
    response_t o;
    o = '{ST_OK, '0, '0, '0, '0, 1'b0};
    case (r.action)
      ACT_ALLOC: begin
        if (bump + r.size >= NCELLS) begin
          collect_heap();
          o.coll = 1;
        end
        if (bump + r.size >= NCELLS) begin
          o.status = ST_OOM;
        end else begin
          o.start = 10'(bump);
          for (int i = 0; i < r.size; i++) begin
            cell_tag_m[bump + i] = TAG_NIL;
            cell_pay_m[bump + i] = 0;
            cell_len_m[bump + i] = 0;
            cell_moved_m[bump + i] = 0;
          end
          bump += r.size;
          if (bump > written_top) written_top = bump;
        end
      end
      ACT_WRITE_CELL: begin
        if (r.addr >= bump) o.status = ST_BAD_ADDR;
        else begin
          cell_tag_m[r.addr] = r.tag;
          cell_pay_m[r.addr] = r.payload;
          cell_len_m[r.addr] = r.len;
        end
      end
      ACT_READ_CELL: begin
        if (r.addr >= bump) o.status = ST_BAD_ADDR;
        else begin
          o.rtag = cell_tag_m[r.addr];
          o.rpay = cell_pay_m[r.addr];
          o.rlen = cell_len_m[r.addr];
        end
      end
      ACT_PUSH_ROOT: begin
        if (root_count >= NROOTS) o.status = ST_OVERFLOW;
        else begin
          root_tag_m[root_count] = r.tag;
          root_pay_m[root_count] = r.payload;
          root_len_m[root_count] = r.len;
          root_count++;
        end
      end
      ACT_POP_ROOT: begin
        if (root_count == 0) o.status = ST_UNDERFLOW;
        else root_count--;
      end
      ACT_READ_ROOT: begin
        if (r.addr >= root_count) o.status = ST_BAD_ADDR;
        else begin
          o.rtag = root_tag_m[r.addr];
          o.rpay = root_pay_m[r.addr];
          o.rlen = root_len_m[r.addr];
        end
      end
      ACT_WRITE_ROOT: begin
        if (r.addr >= root_count) o.status = ST_BAD_ADDR;
        else begin
          root_tag_m[r.addr] = r.tag;
          root_pay_m[r.addr] = r.payload;
          root_len_m[r.addr] = r.len;
        end
      end
      default: begin
        collect_heap();
        o.coll = 1;
      end
    endcase
    if (o.status == ST_OOM) n_oom++;
    if (o.status == ST_BAD_ADDR) n_bad++;
    if (o.status == ST_OVERFLOW) n_ovf++;
    if (o.status == ST_UNDERFLOW) n_unf++;
    return o;
  endfunction

  function automatic request_t make_req(logic [2:0] a, int unsigned sz, int unsigned ad,
                                        logic [3:0] t, logic [31:0] p, int unsigned l);
    request_t r;
    r.action = a;
    r.size = 11'(sz);
    r.addr = 10'(ad);
    r.tag = t;
    r.payload = p;
    r.len = 11'(l);
    return r;
  endfunction

  // value whose reach only covers cells written since reset
  function automatic void random_value(ref request_t r);
    int unsigned k, sp, lim;
    k = $urandom_range(0, 99);
    r.len = 11'($urandom_range(0, 1024));
    if (k < 50 || written_top == 0) begin
      r.tag = 4'($urandom_range(0, TAG_FIRST_REF - 1));
      r.payload = $urandom;
    end else if (k < 90) begin
      r.tag = 4'($urandom_range(TAG_FIRST_REF, TAG_VECTOR));
      if (r.tag == TAG_VECTOR) begin
        lim = (written_top < 12) ? written_top : 12;
        if ($urandom_range(0, 49) == 0) lim = written_top;
        if (lim > 1024) lim = 1024;
        r.len = 11'($urandom_range(1, lim));
      end
      sp = object_span(r.tag, r.len);
      if (sp > written_top) begin
        r.tag = 4'($urandom_range(0, TAG_FIRST_REF - 1));
        r.payload = $urandom;
      end else begin
        r.payload = $urandom_range(0, written_top - sp);
      end
    end else if (k < 95) begin
      r.tag = 4'($urandom_range(TAG_FIRST_REF, TAG_VECTOR));
      r.payload = $urandom_range(NCELLS, 32'hffff_ffff);
    end else begin
      r.tag = TAG_VECTOR;
      r.len = 0;
      r.payload = $urandom_range(0, 1) ? $urandom_range(0, written_top - 1)
                                        : $urandom_range(NCELLS, 32'hffff_ffff);
    end
  endfunction

  function automatic int pick_gap();
    int k;
    if (no_gaps) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input request_t r);
    int gap;
    pending_q.push_back(heap_step(r));
    in_ch.valid = 1;
    in_ch.action = r.action;
    in_ch.alloc_size = r.size;
    in_ch.address = r.addr;
    in_ch.value_tag = r.tag;
    in_ch.value_payload = r.payload;
    in_ch.value_length = r.len;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
    in_ch.valid = 0;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // response side: random stalls, long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 0;
        hold_cycles--;
      end else if (steady_ready) begin
        out_ch.ready = 1;
      end else if (stall > 0) begin
        out_ch.ready = 0;
        stall--;
      end else begin
        out_ch.ready = 1;
        if ($urandom_range(0, 99) < 30)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    response_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.alloc_start, out_ch.read_tag, out_ch.read_payload,
              out_ch.read_length, out_ch.collected};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response status %0d", got.status);
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d: exp st %0d start %0d tag %0d pay %h len %0d col %0d, got st %0d start %0d tag %0d pay %h len %0d col %0d",
                     checked, want.status, want.start, want.rtag, want.rpay, want.rlen,
                     want.coll, got.status, got.start, got.rtag, got.rpay, got.rlen, got.coll);
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_item(make_req(ACT_POP_ROOT, 0, 0, 0, 0, 0));
    send_item(make_req(ACT_READ_ROOT, 0, 0, 0, 0, 0));
    send_item(make_req(ACT_READ_CELL, 0, 0, 0, 0, 0));
    send_item(make_req(ACT_WRITE_CELL, 0, 0, 1, 1, 1));
    send_item(make_req(ACT_WRITE_ROOT, 0, 0, 1, 1, 1));
    send_item(make_req(ACT_COLLECT, 0, 0, 0, 0, 0));
    send_item(make_req(ACT_ALLOC, 0, 0, 0, 0, 0));
    send_item(make_req(ACT_ALLOC, 1024, 0, 0, 0, 0));
    send_item(make_req(ACT_ALLOC, 1023, 0, 0, 0, 0));
    send_item(make_req(ACT_ALLOC, 1022, 0, 0, 0, 0));
    send_item(make_req(ACT_READ_CELL, 0, 0, 0, 0, 0));
    send_item(make_req(ACT_WRITE_CELL, 0, 1021, TAG_VECTOR, 1000, 22));
    send_item(make_req(ACT_READ_CELL, 0, 1021, 0, 0, 0));
    send_item(make_req(ACT_WRITE_CELL, 0, 1020, 0, 32'hffff_ffff, 1024));
    send_item(make_req(ACT_PUSH_ROOT, 0, 0, TAG_FIRST_REF, 1020, 0));
    send_item(make_req(ACT_PUSH_ROOT, 0, 0, TAG_FIRST_REF - 1, 32'hffff_ffff, 1024));
    send_item(make_req(ACT_PUSH_ROOT, 0, 0, TAG_VECTOR - 1, 32'hffff_ffff, 0));
    send_item(make_req(ACT_PUSH_ROOT, 0, 0, TAG_VECTOR, 5, 0));
    send_item(make_req(ACT_PUSH_ROOT, 0, 0, TAG_HASH, 900, 0));
    send_item(make_req(ACT_PUSH_ROOT, 0, 0, TAG_PROC, 3, 0));
    send_item(make_req(ACT_PUSH_ROOT, 0, 0, TAG_MACRO, 1019, 0));
    send_item(make_req(ACT_WRITE_ROOT, 0, 0, TAG_VECTOR, 0, 1022));
    send_item(make_req(ACT_READ_ROOT, 0, 5, 0, 0, 0));
    send_item(make_req(ACT_COLLECT, 0, 0, 0, 0, 0));
    send_item(make_req(ACT_READ_ROOT, 0, 3, 0, 0, 0));
    send_item(make_req(ACT_ALLOC, 1, 0, 0, 0, 0));
    repeat (7) send_item(make_req(ACT_POP_ROOT, 0, 0, 0, 0, 0));
    send_item(make_req(ACT_COLLECT, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(input int count);
    request_t r;
    int k, push_bias;
    push_bias = 10;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        steady_ready = ($urandom_range(0, 3) == 0);
        push_bias = $urandom_range(0, 2) == 0 ? 30 : 8;
      end
      r = make_req(ACT_ALLOC, $urandom_range(0, 2047), $urandom, 4'($urandom), $urandom,
                   $urandom_range(0, 2047));
      k = $urandom_range(0, 99 + push_bias);
      if (k < 20) begin
        r.action = ACT_ALLOC;
        k = $urandom_range(0, 99);
        r.size = 11'((k < 85) ? $urandom_range(1, 12) : (k < 92) ? 0 :
                     (k < 98) ? $urandom_range(13, 200) : $urandom_range(201, 1024));
      end else if (k < 42) begin
        r.action = ACT_WRITE_CELL;
        random_value(r);
        if (bump > 0 && $urandom_range(0, 9) != 0) r.addr = 10'($urandom_range(0, bump - 1));
      end else if (k < 62) begin
        r.action = ACT_READ_CELL;
        if (bump > 0 && $urandom_range(0, 9) != 0) r.addr = 10'($urandom_range(0, bump - 1));
      end else if (k < 69) begin
        r.action = ACT_POP_ROOT;
      end else if (k < 77) begin
        r.action = ACT_READ_ROOT;
        if (root_count > 0 && $urandom_range(0, 9) != 0)
          r.addr = 10'($urandom_range(0, root_count - 1));
      end else if (k < 85) begin
        r.action = ACT_WRITE_ROOT;
        random_value(r);
        if (root_count > 0 && $urandom_range(0, 9) != 0)
          r.addr = 10'($urandom_range(0, root_count - 1));
      end else if (k < 88) begin
        r.action = ACT_COLLECT;
      end else begin
        r.action = ACT_PUSH_ROOT;
        random_value(r);
      end
      send_item(r);
    end
    no_gaps = 0;
    steady_ready = 0;
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_output_stall();
    request_t r;
    no_gaps = 1;
    hold_cycles = 400;
    for (int n = 0; n < 20; n++) begin
      r = make_req(ACT_READ_ROOT, 0, $urandom_range(0, 3), 0, 0, 0);
      send_item(r);
    end
    no_gaps = 0;
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_item(make_req(ACT_COLLECT, 0, 0, 0, 0, 0));
    send_item(make_req(ACT_READ_CELL, 0, 0, 0, 0, 0));
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.action = ACT_ALLOC;
    in_ch.alloc_size = 0;
    in_ch.address = 0;
    in_ch.value_tag = 0;
    in_ch.value_payload = 0;
    in_ch.value_length = 0;
    repeat (2) @(negedge clk);
    rst = 0;
    test_directed_cases();
    test_random_traffic(850);
    test_output_stall();
    test_drain_pause();
    test_random_traffic(850);
    wait_drained();
    repeat (50) @(negedge clk);
    $display("%0d requests sent, %0d responses checked, %0d collections", sent, checked,
             n_collect);
    $display("error codes seen: %0d out of memory, %0d bad address, %0d overflow, %0d underflow",
             n_oom, n_bad, n_ovf, n_unf);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/chc_pkg.sv
rtl/core/chc_in_if.sv
rtl/core/chc_out_if.sv
rtl/core/chc_ctrl.sv
rtl/core/chc_dpath.sv
rtl/core/copying_heap_collector.sv
test/copying_heap_collector_test.sv
